/* design/tkd_pkg.sv */
// Package for the strongest-first sighting table.
// Holds the row type, command codes and shared constants; no dependencies.

package tkd_pkg;

    // Default table depth
    localparam int MAX_ENTRIES_DEF = 16;

    // Name is 32 bytes, kept as four 64-bit words, word 0 holds byte 0
    localparam int NAME_WORDS = 4;
    localparam int WORD_BITS  = 64;
    localparam int NAME_BYTES = 32;

    // Weakest signal kept, in dBm
    localparam logic signed [7:0] SIG_FLOOR = -8'sd127;
    localparam logic signed [7:0] SIG_CEIL  = 8'sd0;

    // Width of the count field on the result item
    localparam int COUNT_BITS = 5;

    // Item commands
    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_OFFER  = 2'd1,
        CMD_FINISH = 2'd2
    } t_cmd;

    typedef logic [NAME_WORDS-1:0][WORD_BITS-1:0] t_name;

    // One table row
    typedef struct packed {
        t_name             name;
        logic signed [7:0] sig;
        logic              enc;
    } t_row;

endpackage

/* design/tkd_if.sv */
// Valid/ready channel interfaces for the sighting table: input and result.
// Plain signals only; no package dependency.

interface tkd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [63:0] name_w0;
    logic [63:0] name_w1;
    logic [63:0] name_w2;
    logic [63:0] name_w3;
    logic signed [7:0] signal_raw;
    logic        is_secure;

    modport source (
        output valid, cmd, name_w0, name_w1, name_w2, name_w3, signal_raw, is_secure,
        input  ready
    );
    modport sink (
        input  valid, cmd, name_w0, name_w1, name_w2, name_w3, signal_raw, is_secure,
        output ready
    );
endinterface

interface tkd_out_if;
    logic        valid;
    logic        ready;
    logic        row_valid;
    logic [63:0] out_w0;
    logic [63:0] out_w1;
    logic [63:0] out_w2;
    logic [63:0] out_w3;
    logic signed [7:0] row_signal;
    logic        row_secure;
    logic [4:0]  row_count;
    logic        last_row;

    modport source (
        output valid, row_valid, out_w0, out_w1, out_w2, out_w3, row_signal, row_secure,
               row_count, last_row,
        input  ready
    );
    modport sink (
        input  valid, row_valid, out_w0, out_w1, out_w2, out_w3, row_signal, row_secure,
               row_count, last_row,
        output ready
    );
endinterface

/* design/tkd_norm.sv */
// Sighting normalizer: cuts the name at its first zero byte, clamps the signal.
// Depends on tkd_pkg.

module tkd_norm (
    input  tkd_pkg::t_name     i_name,
    input  logic signed [7:0]  i_signal_raw,
    input  logic               i_is_secure,
    output tkd_pkg::t_row      o_row,
    output logic               o_empty
);
    import tkd_pkg::*;

    logic [NAME_BYTES-1:0]   byte_zero;
    logic [NAME_BYTES-1:0]   byte_keep;
    logic [NAME_BYTES*8-1:0] flat_in;
    logic [NAME_BYTES*8-1:0] flat_out;

    assign flat_in = i_name;

    // Flag zero bytes
    always_comb begin
        for (int i = 0; i < NAME_BYTES; i++) begin
            byte_zero[i] = (flat_in[8*i +: 8] == 8'h00);
        end
    end

    // A byte survives only if no zero byte sits at or below it
    always_comb begin
        logic [NAME_BYTES-1:0] mask;
        for (int i = 0; i < NAME_BYTES; i++) begin
            mask         = NAME_BYTES'((64'd1 << (i + 1)) - 64'd1);
            byte_keep[i] = ((byte_zero & mask) == '0);
        end
    end

    always_comb begin
        for (int i = 0; i < NAME_BYTES; i++) begin
            flat_out[8*i +: 8] = byte_keep[i] ? flat_in[8*i +: 8] : 8'h00;
        end
    end

    // Clamp to floor..0
    always_comb begin
        o_row.name = flat_out;
        o_row.enc  = i_is_secure;
        if (i_signal_raw < SIG_FLOOR) begin
            o_row.sig = SIG_FLOOR;
        end else if (i_signal_raw > SIG_CEIL) begin
            o_row.sig = SIG_CEIL;
        end else begin
            o_row.sig = i_signal_raw;
        end
    end

    assign o_empty = byte_zero[0];

endmodule

/* design/top_k_dedup_signal_table.sv */
// Offer: one row compared per cycle, then one row shifted per cycle, through the
//   one-read one-write row memory.
// Start and ignored commands leave the block idle; finish passes through a read and a load state per emitted row.
// Input ready is low while an item is in work; a result waits in the output register.
// Synchronous active-low reset empties the table and drops any pending result.
// Depends on tkd_pkg, tkd_if and tkd_norm.

module top_k_dedup_signal_table #(
    parameter int MAX_ENTRIES = tkd_pkg::MAX_ENTRIES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tkd_in_if.sink    i_in,
    tkd_out_if.source o_out
);
    import tkd_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_PREP,
        S_BUBBLE,
        S_EM_RD,
        S_EM_LOAD
    } t_state;

    // Row memory
    t_row mem [MAX_ENTRIES];

    t_state          r_state, n_state;
    logic [AW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_count, n_count;
    t_row            r_ent, n_ent;
    t_row            r_rd_data;
    logic            r_out_valid, n_out_valid;
    t_row            r_out_row, n_out_row;
    logic            r_out_row_valid, n_out_row_valid;
    logic [COUNT_BITS-1:0] r_out_count, n_out_count;
    logic            r_out_last, n_out_last;

    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    t_row            wr_data;

    t_row            norm_row;
    logic            norm_empty;
    logic            in_fire;
    logic            out_free;
    logic            name_hit;
    logic            idx_last;

    tkd_norm u_norm (
        .i_name       ({i_in.name_w3, i_in.name_w2, i_in.name_w1, i_in.name_w0}),
        .i_signal_raw (i_in.signal_raw),
        .i_is_secure  (i_in.is_secure),
        .o_row        (norm_row),
        .o_empty      (norm_empty)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || o_out.ready;
    assign name_hit   = (r_rd_data.name == r_ent.name);
    assign idx_last   = ((CW'(r_idx) + 1'b1) == r_count);

    // Sequencer next state, memory port control
    always_comb begin
        n_state         = r_state;
        n_idx           = r_idx;
        n_count         = r_count;
        n_ent           = r_ent;
        n_out_valid     = r_out_valid && !o_out.ready;
        n_out_row       = r_out_row;
        n_out_row_valid = r_out_row_valid;
        n_out_count     = r_out_count;
        n_out_last      = r_out_last;
        rd_addr         = r_idx;
        wr_en           = 1'b0;
        wr_addr         = r_idx;
        wr_data         = r_ent;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (t_cmd'(i_in.cmd))
                        CMD_START: begin
                            n_count = '0;
                        end
                        CMD_OFFER: begin
                            if (!norm_empty) begin
                                n_ent = norm_row;
                                n_idx = '0;
                                if (r_count == '0) begin
                                    n_count = CW'(1);
                                    n_state = S_PREP;
                                end else begin
                                    rd_addr = '0;
                                    n_state = S_SEARCH;
                                end
                            end
                        end
                        CMD_FINISH: begin
                            n_idx   = '0;
                            n_state = S_EM_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // One row compared per cycle; read of the next row overlaps
            S_SEARCH: begin
                if (name_hit) begin
                    n_state = (r_ent.sig > r_rd_data.sig) ? S_PREP : S_IDLE;
                end else if (idx_last) begin
                    if (r_count < CW'(MAX_ENTRIES)) begin
                        n_idx   = AW'(r_count);
                        n_count = r_count + 1'b1;
                        n_state = S_PREP;
                    end else if (r_ent.sig > r_rd_data.sig) begin
                        n_state = S_PREP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    rd_addr = r_idx + 1'b1;
                    n_idx   = r_idx + 1'b1;
                end
            end

            // Fetch the row ahead of the slot, or place at the head
            S_PREP: begin
                if (r_idx == '0) begin
                    wr_en   = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    rd_addr = r_idx - 1'b1;
                    n_state = S_BUBBLE;
                end
            end

            // Move weaker rows back one place, then drop the entry in
            S_BUBBLE: begin
                wr_en = 1'b1;
                if (r_rd_data.sig < r_ent.sig) begin
                    wr_data = r_rd_data;
                    n_idx   = r_idx - 1'b1;
                    if (r_idx == AW'(1)) begin
                        n_state = S_PREP;
                    end else begin
                        rd_addr = r_idx - AW'(2);
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end

            S_EM_RD: begin
                n_state = S_EM_LOAD;
            end

            // Hand one row to the output register
            S_EM_LOAD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_count = COUNT_BITS'(r_count);
                    if (r_count == '0) begin
                        n_out_row       = '0;
                        n_out_row_valid = 1'b0;
                        n_out_last      = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        n_out_row       = r_rd_data;
                        n_out_row_valid = 1'b1;
                        n_out_last      = idx_last;
                        if (idx_last) begin
                            n_state = S_IDLE;
                        end else begin
                            n_idx   = r_idx + 1'b1;
                            n_state = S_EM_RD;
                        end
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Row memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // State and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx           <= n_idx;
        r_ent           <= n_ent;
        r_out_row       <= n_out_row;
        r_out_row_valid <= n_out_row_valid;
        r_out_count     <= n_out_count;
        r_out_last      <= n_out_last;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.row_valid  = r_out_row_valid;
    assign o_out.out_w0     = r_out_row.name[0];
    assign o_out.out_w1     = r_out_row.name[1];
    assign o_out.out_w2     = r_out_row.name[2];
    assign o_out.out_w3     = r_out_row.name[3];
    assign o_out.row_signal = r_out_row.sig;
    assign o_out.row_secure = r_out_row.enc;
    assign o_out.row_count  = r_out_count;
    assign o_out.last_row   = r_out_last;

endmodule

/* design/tkd_chk.sv */
// Port-level checks for the sighting table, bound to the top level.
// Depends on tkd_pkg and top_k_dedup_signal_table.

module tkd_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [1:0]  i_cmd,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_row_valid,
    input logic [63:0] i_out_w0,
    input logic [63:0] i_out_w3,
    input logic [7:0]  i_row_signal,
    input logic [4:0]  i_row_count,
    input logic        i_last_row
);
    import tkd_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_w0)
            && $stable(i_out_w3) && $stable(i_row_signal) && $stable(i_last_row))
        else $error("result changed while stalled");

    // Finish keeps the block busy while it emits
    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_cmd == CMD_FINISH) |=> !i_in_ready)
        else $error("input taken during emit");

    // Empty-table result is all zero and ends the run
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_row_valid |-> i_last_row && (i_row_count == 5'd0)
            && (i_row_signal == 8'd0))
        else $error("bad empty-table result");

    // Row signals stay in the clamped range
    a_sig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_row_valid |-> (i_row_signal[7] || (i_row_signal == 8'd0))
            && (i_row_signal != 8'h80))
        else $error("row signal out of range");

    // Reset drops the result and frees the input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("not idle after reset");

endmodule

bind top_k_dedup_signal_table tkd_chk u_tkd_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_cmd        (i_in.cmd),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_row_valid  (o_out.row_valid),
    .i_out_w0     (o_out.out_w0),
    .i_out_w3     (o_out.out_w3),
    .i_row_signal (o_out.row_signal),
    .i_row_count  (o_out.row_count),
    .i_last_row   (o_out.last_row)
);

/* dv/top_k_dedup_signal_table_checker.sv */
// Checker for the strongest-first sighting table: keeps its own copy of the table,
// predicts every dump row and compares it with the result channel field by field.
// Depends on tkd_pkg and the channel interfaces in tkd_if.
`timescale 1ns / 1ps

module top_k_dedup_signal_table_checker #(
    parameter int DEPTH = tkd_pkg::MAX_ENTRIES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tkd_in_if    i_in_mon,
    tkd_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_rows_checked
);
    import tkd_pkg::*;

    // One row of a table dump as it should leave the block
    typedef struct {
        logic                  row_valid;
        t_name                 name;
        logic signed [7:0]     sig;
        logic                  enc;
        logic [COUNT_BITS-1:0] count;
        logic                  last;
    } t_dump_row;

    t_dump_row rows_due[$];

    // Shadow table, strongest first
    t_name             tbl_name[DEPTH];
    logic signed [7:0] tbl_sig[DEPTH];
    logic              tbl_enc[DEPTH];
    int                tbl_held = 0;

    int mismatches   = 0;
    int rows_checked = 0;

    // A name ends at its first zero byte; everything after reads as zero
    function automatic t_name trim_name(input t_name raw);
        logic [NAME_WORDS*WORD_BITS-1:0] src;
        logic [NAME_WORDS*WORD_BITS-1:0] dst;
        bit                              ended;
        src   = raw;
        dst   = '0;
        ended = 1'b0;
        for (int i = 0; i < NAME_BYTES; i++) begin
            if (src[8*i +: 8] == 8'h00) ended = 1'b1;
            if (!ended) dst[8*i +: 8] = src[8*i +: 8];
        end
        return dst;
    endfunction

    // Dedup by name, insert or replace the weakest row, then bubble forward
    function automatic void apply_sighting(input t_name raw, input logic signed [7:0] s_raw,
                                           input logic sec);
        t_name             nm;
        logic signed [7:0] s;
        int                hit;
        int                slot;
        int                pos;
        nm = trim_name(raw);
        if (nm[0][7:0] == 8'h00) return;
        s = s_raw;
        if (s > SIG_CEIL)  s = SIG_CEIL;
        if (s < SIG_FLOOR) s = SIG_FLOOR;

        hit = -1;
        for (int j = 0; j < tbl_held; j++) begin
            if (hit < 0 && tbl_name[j] == nm) hit = j;
        end

        if (hit >= 0) begin
            // known name: only a strictly stronger sighting counts
            if (s <= tbl_sig[hit]) return;
            slot = hit;
        end else if (tbl_held < DEPTH) begin
            slot = tbl_held;
            tbl_held++;
        end else if (s > tbl_sig[tbl_held-1]) begin
            slot = tbl_held - 1;
        end else begin
            return;
        end

        // stable move: pass only strictly weaker rows
        pos = slot;
        while (pos > 0 && tbl_sig[pos-1] < s) begin
            tbl_name[pos] = tbl_name[pos-1];
            tbl_sig[pos]  = tbl_sig[pos-1];
            tbl_enc[pos]  = tbl_enc[pos-1];
            pos--;
        end
        tbl_name[pos] = nm;
        tbl_sig[pos]  = s;
        tbl_enc[pos]  = sec;
    endfunction

    // Finish: one row per entry, or a single empty marker row
    function automatic void dump_table_rows();
        t_dump_row r;
        if (tbl_held == 0) begin
            r.row_valid = 1'b0;
            r.name      = '0;
            r.sig       = '0;
            r.enc       = 1'b0;
            r.count     = '0;
            r.last      = 1'b1;
            rows_due.push_back(r);
        end else begin
            for (int k = 0; k < tbl_held; k++) begin
                r.row_valid = 1'b1;
                r.name      = tbl_name[k];
                r.sig       = tbl_sig[k];
                r.enc       = tbl_enc[k];
                r.count     = COUNT_BITS'(tbl_held);
                r.last      = (k == tbl_held - 1);
                rows_due.push_back(r);
            end
        end
    endfunction

    task automatic check_field(input string fname, input logic [63:0] expv,
                               input logic [63:0] gotv);
        if (gotv !== expv) begin
            $error("%s: expected %0h, got %0h", fname, expv, gotv);
            mismatches++;
        end
    endtask

    // Watch both channels; results are checked before this edge's input is applied
    always @(posedge i_clk) begin : watch
        t_dump_row want;
        if (!i_rst_n) begin
            tbl_held = 0;
            rows_due.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (rows_due.size() == 0) begin
                    $error("result item arrived with no dump row due");
                    mismatches++;
                end else begin
                    want = rows_due.pop_front();
                    check_field("row_valid",  64'(want.row_valid), 64'(i_out_mon.row_valid));
                    check_field("out_w0",     want.name[0],        i_out_mon.out_w0);
                    check_field("out_w1",     want.name[1],        i_out_mon.out_w1);
                    check_field("out_w2",     want.name[2],        i_out_mon.out_w2);
                    check_field("out_w3",     want.name[3],        i_out_mon.out_w3);
                    check_field("row_signal", 64'(want.sig[7:0]),  64'(i_out_mon.row_signal[7:0]));
                    check_field("row_secure", 64'(want.enc),       64'(i_out_mon.row_secure));
                    check_field("row_count",  64'(want.count),     64'(i_out_mon.row_count));
                    check_field("last_row",   64'(want.last),      64'(i_out_mon.last_row));
                    rows_checked++;
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                case (i_in_mon.cmd)
                    CMD_START: begin
                        tbl_held = 0;
                    end
                    CMD_OFFER: begin
                        apply_sighting({i_in_mon.name_w3, i_in_mon.name_w2,
                                        i_in_mon.name_w1, i_in_mon.name_w0},
                                       i_in_mon.signal_raw, i_in_mon.is_secure);
                    end
                    CMD_FINISH: begin
                        dump_table_rows();
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_fail_count   <= mismatches;
        o_pending      <= rows_due.size();
        o_rows_checked <= rows_checked;
    end

endmodule

/* dv/top_k_dedup_signal_table_test.sv */
// Testbench top for the strongest-first sighting table: clock, reset, item stimulus,
// result-side stalls, watchdog and verdict. Checking lives in the checker module.
// Depends on tkd_pkg, tkd_if, the block and top_k_dedup_signal_table_checker.
`timescale 1ns / 1ps

module top_k_dedup_signal_table_test;
    import tkd_pkg::*;

    localparam int         ITEM_GOAL   = 310;
    localparam int         POOL_SIZE   = 24;
    // the tail lets the longest offer end and a dump row wait out a receiver stall
    localparam int         TAIL_CYCLES = 2 * MAX_ENTRIES_DEF + 8;
    localparam int         STALL_LIMIT = 4000;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tkd_in_if  in_ch ();
    tkd_out_if out_ch ();

    int fail_count;
    int rows_pending;
    int rows_checked;

    int tx_idle_pct;
    int rx_idle_pct;
    int stall_cycles = 0;

    int n_start   = 0;
    int n_offer   = 0;
    int n_finish  = 0;
    int n_ignored = 0;
    int n_counted = 0;

    logic [NAME_WORDS*WORD_BITS-1:0] name_pool[POOL_SIZE];
    int                              pool_len[POOL_SIZE];

    top_k_dedup_signal_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    top_k_dedup_signal_table_checker u_table_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_mon       (in_ch),
        .i_out_mon      (out_ch),
        .o_fail_count   (fail_count),
        .o_pending      (rows_pending),
        .o_rows_checked (rows_checked)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver: random stalls at the current rate
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: nothing moving on either channel for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles, %0d dump rows due",
                     stall_cycles, rows_pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [NAME_WORDS*WORD_BITS-1:0] random_bits();
        logic [NAME_WORDS*WORD_BITS-1:0] v;
        for (int i = 0; i < NAME_WORDS * 2; i++) v[32*i +: 32] = $urandom();
        return v;
    endfunction

    // Regenerate some pool names: mostly short, some filling all 32 bytes
    task automatic refresh_pool(input int pct);
        for (int p = 0; p < POOL_SIZE; p++) begin
            if ($urandom_range(99) < pct) begin
                pool_len[p]  = ($urandom_range(9) == 0) ? NAME_BYTES : $urandom_range(1, 12);
                name_pool[p] = '0;
                for (int i = 0; i < pool_len[p]; i++) begin
                    name_pool[p][8*i +: 8] = 8'($urandom_range(1, 255));
                end
            end
        end
    endtask

    // Sighting name: pool names (some with junk past the terminator), random words,
    // or an empty name
    function automatic logic [NAME_WORDS*WORD_BITS-1:0] sighting_name();
        logic [NAME_WORDS*WORD_BITS-1:0] nm;
        int                              idx;
        int                              r;
        r = $urandom_range(99);
        if (r < 88) begin
            idx = $urandom_range(POOL_SIZE - 1);
            nm  = name_pool[idx];
            if (pool_len[idx] < NAME_BYTES && $urandom_range(2) == 0) begin
                for (int i = pool_len[idx] + 1; i < NAME_BYTES; i++) begin
                    nm[8*i +: 8] = 8'($urandom());
                end
            end
        end else if (r < 94) begin
            nm = random_bits();
        end else begin
            nm        = random_bits();
            nm[7:0]   = 8'h00;
        end
        return nm;
    endfunction

    // Coarse steps give plenty of equal signals; the rest spans the whole byte
    function automatic logic signed [7:0] random_signal();
        if ($urandom_range(9) < 7) return -8'($urandom_range(0, 25) * 5);
        return 8'($urandom());
    endfunction

    // Present one item after a random gap and hold it until accepted
    task automatic send_item(input logic [1:0] op, input logic [NAME_WORDS*WORD_BITS-1:0] nm,
                             input logic signed [7:0] sig, input logic sec);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= op;
        in_ch.name_w0    <= nm[63:0];
        in_ch.name_w1    <= nm[127:64];
        in_ch.name_w2    <= nm[191:128];
        in_ch.name_w3    <= nm[255:192];
        in_ch.signal_raw <= sig;
        in_ch.is_secure  <= sec;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);

        case (op)
            CMD_START:  n_start++;
            CMD_OFFER:  n_offer++;
            CMD_FINISH: n_finish++;
            default:    ;
        endcase
        if (op == CMD_UNUSED || (op == CMD_OFFER && nm[7:0] == 8'h00)) begin
            n_ignored++;
        end else begin
            n_counted++;
        end
    endtask

    // Hold off the sender until every dump row has come out
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (rows_pending != 0);
    endtask

    initial begin
        logic [NAME_WORDS*WORD_BITS-1:0] name_a;
        logic [NAME_WORDS*WORD_BITS-1:0] name_b;
        logic [NAME_WORDS*WORD_BITS-1:0] name_b_junk;
        logic [NAME_WORDS*WORD_BITS-1:0] name_empty;
        int                              phase;
        int                              next_phase;
        int                              scan_len;
        int                              pick;

        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.cmd        = CMD_START;
        in_ch.name_w0    = '0;
        in_ch.name_w1    = '0;
        in_ch.name_w2    = '0;
        in_ch.name_w3    = '0;
        in_ch.signal_raw = '0;
        in_ch.is_secure  = 1'b0;
        tx_idle_pct      = 36;
        rx_idle_pct     <= 58;
        phase            = 0;

        name_a      = {192'h0, 64'h0000_0000_0041_5054};
        name_b      = {192'h0, 64'h0000_6e65_6472_6167};
        // same name as b once cut at the zero byte
        name_b_junk = {64'hdead_beef_0102_0304, 64'h5a5a_a5a5_ffff_0001,
                       64'h8000_0000_0000_0080, 64'h7700_6e65_6472_6167};
        name_empty  = {64'hffff_ffff_ffff_ffff, 64'h0123_4567_89ab_cdef,
                       64'hfedc_ba98_7654_3210, 64'h1234_5678_9abc_de00};
        refresh_pool(100);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty dump, unused command, clamping, dedup, ties, embedded zero
        send_item(CMD_FINISH, '0, 8'sd0, 1'b0);
        send_item(CMD_UNUSED, name_a, -8'sd30, 1'b1);
        send_item(CMD_START, '0, 8'sd0, 1'b0);
        send_item(CMD_OFFER, name_a, 8'sd127, 1'b1);
        send_item(CMD_OFFER, name_a, -8'sd50, 1'b0);
        send_item(CMD_OFFER, name_a, 8'sd0, 1'b0);
        send_item(CMD_OFFER, name_empty, -8'sd10, 1'b1);
        send_item(CMD_OFFER, name_b, -8'sd128, 1'b0);
        send_item(CMD_OFFER, name_b_junk, -8'sd60, 1'b1);
        send_item(CMD_OFFER, '1, -8'sd60, 1'b0);
        send_item(CMD_OFFER, name_pool[0] | {NAME_BYTES{8'h01}}, -8'sd90, 1'b1);
        send_item(CMD_OFFER, '1, -8'sd20, 1'b1);
        send_item(CMD_UNUSED, '1, 8'sd127, 1'b0);
        send_item(CMD_FINISH, '0, 8'sd0, 1'b0);
        send_item(CMD_FINISH, '1, -8'sd1, 1'b1);
        send_item(CMD_START, '0, 8'sd0, 1'b0);
        send_item(CMD_FINISH, '0, 8'sd0, 1'b0);

        // Random: mostly full scans with pooled names so the table fills and replaces
        while (n_counted < ITEM_GOAL) begin
            next_phase = (n_counted * 3) / ITEM_GOAL;
            if (next_phase > 2) next_phase = 2;
            if (next_phase != phase) begin
                phase = next_phase;
                drain_results();
                tx_idle_pct  = (phase == 1) ? 58 : 0;
                rx_idle_pct <= (phase == 1) ? 36 : 0;
            end

            pick = $urandom_range(99);
            if (pick < 80) begin
                refresh_pool(20);
                send_item(CMD_START, random_bits(), random_signal(), 1'($urandom()));
                scan_len = $urandom_range(1, 40);
                for (int k = 0; k < scan_len; k++) begin
                    if ($urandom_range(29) == 0) begin
                        send_item(CMD_UNUSED, random_bits(), random_signal(), 1'($urandom()));
                    end else begin
                        send_item(CMD_OFFER, sighting_name(), random_signal(), 1'($urandom()));
                    end
                end
                send_item(CMD_FINISH, random_bits(), random_signal(), 1'($urandom()));
            end else if (pick < 90) begin
                send_item(CMD_FINISH, random_bits(), random_signal(), 1'($urandom()));
            end else if (pick < 95) begin
                send_item(CMD_UNUSED, random_bits(), random_signal(), 1'($urandom()));
            end else begin
                send_item(CMD_OFFER, sighting_name(), random_signal(), 1'($urandom()));
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d items: %0d scan starts, %0d sightings, %0d dumps, %0d ignored.",
                 n_counted + n_ignored, n_start, n_offer, n_finish, n_ignored);
        $display("Checked %0d dump rows across three sender/receiver pacing phases.",
                 rows_checked);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
